[rtl/core/fpe_pkg.sv]
// Package for the frame peak extraction block: field widths, capacity,
// register indexes and the command/status structs between control and datapath.
// No dependencies.
package fpe_pkg;

   localparam int MAX_POINTS = 64;
   localparam int PT_AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   localparam int FRAME_W   = 32;
   localparam int COORD_W   = 10;
   localparam int BRIGHT_W  = 16;
   localparam int ENTRY_W   = 2 * COORD_W + BRIGHT_W;
   localparam int PAYLOAD_W = FRAME_W + 2 * COORD_W + BRIGHT_W;
   localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
   localparam int PAD_W     = TDATA_W - PAYLOAD_W;

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 16;

   localparam logic [CSR_AW-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_WINDOW_X  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_WINDOW_Y  = 2'd2;

   localparam logic [BRIGHT_W-1:0] THRESHOLD_RST = 16'd100;
   localparam logic [COORD_W-1:0]  WINDOW_RST    = 10'd5;

   typedef struct packed {
      logic load;       // request accepted, store the point
      logic close;      // accepted request ends the frame
      logic commit;     // best point becomes peak, start next pass
      logic emit;       // pending peak goes to the output register
      logic last;       // emitted peak is the frame's last
      logic finish;     // frame done, clear the store
   } fpe_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic qualify;
      logic pend_valid;
      logic out_free;
   } fpe_sts_type;

endpackage

[rtl/core/frame_peak_extraction.sv]
// Frame peak extraction, top level: controller plus datapath.
// Uses fpe_pkg, fpe_ctrl and fpe_dpath.
//
// Bright points are taken one request per cycle into a 64-entry store; points
// beyond capacity are dropped and flagged in rsp_tuser. The request with tlast
// closes the frame and starts extraction, during which no request is taken.
// Each extraction pass reads the N stored points through the single read port
// of the point memory, suppressing around the previous peak while it finds the
// brightest remaining one. Extraction runs after the frame's closing request;
// a pass that emits a result waits while the output register is stalled.
// The last result still waiting in the output register does not hold off the
// next frame's requests.
module frame_peak_extraction
   import fpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [TDATA_W-1:0]  req_tdata,  // frame_number, x_coord, y_coord, pixel_brightness
   input  logic                req_tlast,  // frame_end
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata,  // peak_frame, peak_x, peak_y, peak_brightness
   output logic                rsp_tlast,  // last_peak
   output logic                rsp_tuser,  // frame_overflowed
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata
);

   fpe_cmd_type cmd;
   fpe_sts_type sts;

   fpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

   fpe_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[rtl/core/fpe_dpath.sv]
// Datapath of the frame peak extraction block: point memory, live bits,
// scan pipeline, pending peak and output register. Uses fpe_pkg.
module fpe_dpath
   import fpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  fpe_cmd_type         cmd,
   output fpe_sts_type         sts,
   input  logic [TDATA_W-1:0]  req_tdata,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [CSR_DW-1:0]   csr_wdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser
);

   logic [BRIGHT_W-1:0] thr_ff;
   logic [COORD_W-1:0]  wx_ff, wy_ff;

   logic [ENTRY_W-1:0]  mem [MAX_POINTS];
   logic [CNT_W-1:0]    cnt_ff;
   logic                ovf_ff;
   logic                full;
   logic [FRAME_W-1:0]  frame_ff;
   logic                frame_ovf_ff;

   logic [MAX_POINTS-1:0] live_ff;
   logic                scan_act_ff;
   logic [CNT_W-1:0]    scan_idx_ff;
   logic                rd_issue;
   logic                rd_vld_ff;
   logic [PT_AW-1:0]    rd_idx_ff;
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic [COORD_W-1:0]  rd_x, rd_y, dx, dy;
   logic [BRIGHT_W-1:0] rd_b;
   logic                supp, cand, better;

   logic                has_ctr_ff;
   logic [COORD_W-1:0]  ctr_x_ff, ctr_y_ff;
   logic                best_fnd_ff;
   logic [COORD_W-1:0]  best_x_ff, best_y_ff;
   logic [BRIGHT_W-1:0] best_b_ff;

   logic                pend_vld_ff;
   logic [COORD_W-1:0]  pend_x_ff, pend_y_ff;
   logic [BRIGHT_W-1:0] pend_b_ff;

   logic                rsp_vld_ff;
   logic [FRAME_W-1:0]  rsp_frame_ff;
   logic [COORD_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic [BRIGHT_W-1:0] rsp_b_ff;
   logic                rsp_last_ff, rsp_ovf_ff;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RST;
         wx_ff  <= WINDOW_RST;
         wy_ff  <= WINDOW_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_THRESHOLD: thr_ff <= csr_wdata[BRIGHT_W-1:0];
            CSR_WINDOW_X:  wx_ff  <= csr_wdata[COORD_W-1:0];
            CSR_WINDOW_Y:  wy_ff  <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // point store
   assign full = (cnt_ff == CNT_W'(MAX_POINTS));

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         mem[cnt_ff[PT_AW-1:0]] <= {req_tdata[FRAME_W+ENTRY_W-1:FRAME_W+2*COORD_W],
                                    req_tdata[FRAME_W+2*COORD_W-1:FRAME_W+COORD_W],
                                    req_tdata[FRAME_W+COORD_W-1:FRAME_W]};
      end
      if (rd_issue) begin
         rd_data_ff <= mem[scan_idx_ff[PT_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.finish) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.load) begin
         if (full) ovf_ff <= 1'b1;
         else      cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.close) begin
         frame_ff     <= req_tdata[FRAME_W-1:0];
         frame_ovf_ff <= ovf_ff | full;
      end
   end

   // scan pipeline: read, then compare against best and suppress
   assign rd_issue       = scan_act_ff && (scan_idx_ff != cnt_ff);
   assign sts.scan_done  = scan_act_ff && !rd_issue && !rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_act_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= rd_issue;
         if (cmd.close || cmd.commit) begin
            scan_act_ff <= 1'b1;
            scan_idx_ff <= '0;
         end else if (sts.scan_done) begin
            scan_act_ff <= 1'b0;
         end else if (rd_issue) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
      end
      if (rd_issue) rd_idx_ff <= scan_idx_ff[PT_AW-1:0];
   end

   assign rd_x   = rd_data_ff[COORD_W-1:0];
   assign rd_y   = rd_data_ff[2*COORD_W-1:COORD_W];
   assign rd_b   = rd_data_ff[ENTRY_W-1:2*COORD_W];
   assign dx     = (rd_x >= ctr_x_ff) ? rd_x - ctr_x_ff : ctr_x_ff - rd_x;
   assign dy     = (rd_y >= ctr_y_ff) ? rd_y - ctr_y_ff : ctr_y_ff - rd_y;
   assign supp   = has_ctr_ff && (dx <= wx_ff) && (dy <= wy_ff);
   assign cand   = rd_vld_ff && live_ff[rd_idx_ff] && !supp;
   assign better = cand && (!best_fnd_ff || rd_b >= best_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff     <= '0;
         best_fnd_ff <= 1'b0;
         has_ctr_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         if (cmd.close) begin
            live_ff <= '1;
         end else if (rd_vld_ff && supp) begin
            live_ff[rd_idx_ff] <= 1'b0;
         end

         if (cmd.close || cmd.commit) begin
            best_fnd_ff <= 1'b0;
         end else if (better) begin
            best_fnd_ff <= 1'b1;
         end

         if (cmd.close) begin
            has_ctr_ff  <= 1'b0;
            pend_vld_ff <= 1'b0;
         end else if (cmd.commit) begin
            has_ctr_ff  <= 1'b1;
            pend_vld_ff <= 1'b1;
         end else if (cmd.finish) begin
            pend_vld_ff <= 1'b0;
         end
      end
      if (better) begin
         best_x_ff <= rd_x;
         best_y_ff <= rd_y;
         best_b_ff <= rd_b;
      end
      if (cmd.commit) begin
         ctr_x_ff  <= best_x_ff;
         ctr_y_ff  <= best_y_ff;
         pend_x_ff <= best_x_ff;
         pend_y_ff <= best_y_ff;
         pend_b_ff <= best_b_ff;
      end
   end

   assign sts.qualify    = best_fnd_ff && (best_b_ff >= thr_ff);
   assign sts.pend_valid = pend_vld_ff;
   assign sts.out_free   = !rsp_vld_ff || rsp_tready;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_frame_ff <= frame_ff;
         rsp_x_ff     <= pend_x_ff;
         rsp_y_ff     <= pend_y_ff;
         rsp_b_ff     <= pend_b_ff;
         rsp_last_ff  <= cmd.last;
         rsp_ovf_ff   <= frame_ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_b_ff, rsp_y_ff, rsp_x_ff, rsp_frame_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

[rtl/core/fpe_ctrl.sv]
// Controller of the frame peak extraction block: loads points, sequences
// extraction passes and result emission. Uses fpe_pkg.
module fpe_ctrl
   import fpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tlast,
   output fpe_cmd_type cmd,
   input  fpe_sts_type sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT_MORE,
      ST_EMIT_LAST
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid && req_tlast) begin
               cmd.close = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.qualify && !sts.pend_valid) begin
               cmd.commit = 1'b1;
               state_in   = ST_SCAN;
            end else if (sts.qualify) begin
               state_in = ST_EMIT_MORE;
            end else if (sts.pend_valid) begin
               state_in = ST_EMIT_LAST;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_EMIT_MORE: begin
            if (sts.out_free) begin
               cmd.emit   = 1'b1;
               cmd.commit = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_EMIT_LAST: begin
            if (sts.out_free) begin
               cmd.emit   = 1'b1;
               cmd.last   = 1'b1;
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[sim/tb_frame_peak_extraction.sv]
`timescale 1ns / 100ps
// Self-checking bench for frame_peak_extraction: streams bright-point requests, predicts
// peaks per closed frame, checks each response field. Needs fpe_pkg and the block RTL.
module tb_frame_peak_extraction;
   import fpe_pkg::*;

   localparam int SETTLE_CYCLES = 300;

   typedef struct packed {
      logic [FRAME_W-1:0]  frame;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [BRIGHT_W-1:0] bright;
      logic                fend;
   } point_req_type;

   typedef struct packed {
      logic [FRAME_W-1:0]  frame;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [BRIGHT_W-1:0] bright;
      logic                last;
      logic                ovf;
   } peak_rec_type;

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata  = '0;
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic               rsp_tlast;
   logic               rsp_tuser;
   logic               csr_we     = 1'b0;
   logic [CSR_AW-1:0]  csr_addr   = '0;
   logic [CSR_DW-1:0]  csr_wdata  = '0;

   frame_peak_extraction dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   point_req_type pending_points[$];
   peak_rec_type  awaited_peaks[$];
   int         queued_count   = 0;
   int         accepted_count = 0;
   int         errors         = 0;
   int         idle_left      = 0;
   int         stall_left     = 0;
   bit         req_idle_en    = 1'b1;
   bit         rsp_idle_en    = 1'b1;

   // mirror of the block's registers and point store
   logic [BRIGHT_W-1:0] thr_cfg   = THRESHOLD_RST;
   logic [COORD_W-1:0]  win_x_cfg = WINDOW_RST;
   logic [COORD_W-1:0]  win_y_cfg = WINDOW_RST;
   logic [COORD_W-1:0]  st_x [MAX_POINTS];
   logic [COORD_W-1:0]  st_y [MAX_POINTS];
   logic [BRIGHT_W-1:0] st_b [MAX_POINTS];
   int                  pt_count = 0;
   bit                  pt_ovf   = 1'b0;
   logic [BRIGHT_W-1:0] last_bright = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("frame_peak_extraction regression: fail");
      $finish;
   end

   function automatic logic [COORD_W-1:0] coord_gap(input logic [COORD_W-1:0] a, b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // store one accepted point; on frame close run greedy extraction with suppression
   task automatic take_point(input point_req_type pt);
      bit                  live [MAX_POINTS];
      bit                  found;
      bit                  have;
      int                  best;
      logic [BRIGHT_W-1:0] bb;
      peak_rec_type        held;
      if (pt_count < MAX_POINTS) begin
         st_x[pt_count] = pt.x;
         st_y[pt_count] = pt.y;
         st_b[pt_count] = pt.bright;
         pt_count++;
      end else begin
         pt_ovf = 1'b1;
      end
      if (!pt.fend) return;
      for (int i = 0; i < MAX_POINTS; i++) live[i] = (i < pt_count);
      have = 1'b0;
      best = 0;
      bb   = '0;
      held = '0;
      forever begin
         found = 1'b0;
         for (int i = 0; i < pt_count; i++) begin
            if (live[i] && (!found || st_b[i] >= bb)) begin
               found = 1'b1;
               best  = i;
               bb    = st_b[i];
            end
         end
         if (!found || bb < thr_cfg) break;
         if (have) awaited_peaks = {awaited_peaks, held};
         held.frame  = pt.frame;
         held.x      = st_x[best];
         held.y      = st_y[best];
         held.bright = bb;
         held.last   = 1'b0;
         held.ovf    = pt_ovf;
         have        = 1'b1;
         for (int i = 0; i < pt_count; i++) begin
            if (coord_gap(st_x[i], held.x) <= win_x_cfg &&
                coord_gap(st_y[i], held.y) <= win_y_cfg)
               live[i] = 1'b0;
         end
         live[best] = 1'b0;
      end
      if (have) begin
         held.last = 1'b1;
         awaited_peaks = {awaited_peaks, held};
      end
      pt_count = 0;
      pt_ovf   = 1'b0;
   endtask

   task automatic check_field(input string what, input logic [31:0] want, got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
         errors++;
      end
   endtask

   // request side
   always @(posedge clock) begin : req_side
      point_req_type nxt;
      point_req_type seen;
      if (reset) begin
         req_tvalid <= 1'b0;
         idle_left  <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            seen.frame  = req_tdata[FRAME_W-1:0];
            seen.x      = req_tdata[FRAME_W +: COORD_W];
            seen.y      = req_tdata[FRAME_W+COORD_W +: COORD_W];
            seen.bright = req_tdata[FRAME_W+2*COORD_W +: BRIGHT_W];
            seen.fend   = req_tlast;
            take_point(seen);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (idle_left != 0) begin
               idle_left  <= idle_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_points.size() != 0 && req_idle_en &&
                         $urandom_range(0, 6) == 0) begin
               idle_left  <= $urandom_range(0, 4);
               req_tvalid <= 1'b0;
            end else if (pending_points.size() != 0) begin
               nxt = pending_points.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{PAD_W{1'b0}}, nxt.bright, nxt.y, nxt.x, nxt.frame};
               req_tlast  <= nxt.fend;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response side
   always @(posedge clock) begin : rsp_side
      peak_rec_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_peaks.size() == 0) begin
               $display("%0t: unexpected peak: expected none, got %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = awaited_peaks.pop_front();
               check_field("peak_frame", want.frame, rsp_tdata[FRAME_W-1:0]);
               check_field("peak_x", 32'(want.x), 32'(rsp_tdata[FRAME_W +: COORD_W]));
               check_field("peak_y", 32'(want.y),
                           32'(rsp_tdata[FRAME_W+COORD_W +: COORD_W]));
               check_field("peak_brightness", 32'(want.bright),
                           32'(rsp_tdata[FRAME_W+2*COORD_W +: BRIGHT_W]));
               check_field("last_peak", 32'(want.last), 32'(rsp_tlast));
               check_field("frame_overflowed", 32'(want.ovf), 32'(rsp_tuser));
            end
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_point(input logic [FRAME_W-1:0] fno, input logic [COORD_W-1:0] x, y,
                             input logic [BRIGHT_W-1:0] b, input logic fend);
      point_req_type p;
      p.frame  = fno;
      p.x      = x;
      p.y      = y;
      p.bright = b;
      p.fend   = fend;
      pending_points = {pending_points, p};
      queued_count++;
   endtask

   task automatic queue_frame(input int n);
      logic [FRAME_W-1:0]  fno;
      logic [COORD_W-1:0]  cx, cy, x, y;
      logic [BRIGHT_W-1:0] b;
      int                  spread;
      fno    = $urandom;
      cx     = COORD_W'($urandom);
      cy     = COORD_W'($urandom);
      spread = $urandom_range(1, 12);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
         end else begin
            x = COORD_W'(int'(cx) + $urandom_range(0, 2 * spread) - spread);
            y = COORD_W'(int'(cy) + $urandom_range(0, 2 * spread) - spread);
         end
         case ($urandom_range(0, 9))
            0:       b = '0;
            1:       b = '1;
            2:       b = thr_cfg - 1'b1;
            3:       b = thr_cfg;
            4:       b = thr_cfg + 1'b1;
            5, 6:    b = last_bright;
            default: b = BRIGHT_W'($urandom);
         endcase
         last_bright = b;
         push_point(fno, x, y, b, k == n - 1);
      end
   endtask

   task automatic queue_random(input int budget, input int first_n);
      int total;
      int n;
      total = 0;
      if (first_n > 0) begin
         queue_frame(first_n);
         total = first_n;
      end
      while (total < budget) begin
         n = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 12);
         queue_frame(n);
         total += n;
      end
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      case (addr)
         CSR_THRESHOLD: thr_cfg   = data;
         CSR_WINDOW_X:  win_x_cfg = data[COORD_W-1:0];
         CSR_WINDOW_Y:  win_y_cfg = data[COORD_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sender holds off until every request is taken and every peak is back
   task automatic settle();
      do @(posedge clock);
      while (accepted_count != queued_count || awaited_peaks.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // corners, brightness ties, window edges, closing point below threshold
      push_point(32'hFFFF_FFFF, 10'd0,    10'd0,    16'd0,     1'b0);
      push_point(32'hFFFF_FFFF, 10'd1023, 10'd1023, 16'hFFFF,  1'b0);
      push_point(32'hFFFF_FFFF, 10'd1018, 10'd1023, 16'hFFFF,  1'b0);
      push_point(32'hFFFF_FFFF, 10'd1023, 10'd1017, 16'd500,   1'b0);
      push_point(32'hFFFF_FFFF, 10'd5,    10'd5,    16'd100,   1'b0);
      push_point(32'hFFFF_FFFF, 10'd6,    10'd0,    16'd99,    1'b1);
      push_point(32'h0000_0000, 10'd512,  10'd512,  16'd99,    1'b1);
      push_point(32'h5A5A_A5A5, 10'd100,  10'd200,  16'd300,   1'b0);
      push_point(32'h5A5A_A5A5, 10'd100,  10'd200,  16'd300,   1'b0);
      push_point(32'h5A5A_A5A5, 10'd95,   10'd205,  16'd300,   1'b0);
      push_point(32'h5A5A_A5A5, 10'd106,  10'd200,  16'd300,   1'b0);
      push_point(32'h5A5A_A5A5, 10'd300,  10'd300,  16'd100,   1'b1);
      push_point(32'h8000_0001, 10'd1023, 10'd0,    16'hFFFF,  1'b1);
      push_point(32'h1234_5678, 10'd512,  10'd0,    16'hFFFF,  1'b0);
      push_point(32'h1234_5678, 10'd512,  10'd0,    16'd0,     1'b1);
      settle();

      // threshold zero, point windows: only points at a peak's exact coordinates are suppressed
      write_csr(CSR_THRESHOLD, 16'd0);
      write_csr(CSR_WINDOW_X, 16'd0);
      write_csr(CSR_WINDOW_Y, 16'd0);
      rsp_idle_en = 1'b0;
      queue_random(70, 0);
      settle();

      // top threshold, full windows, overflowing frame
      write_csr(CSR_THRESHOLD, 16'hFFFF);
      write_csr(CSR_WINDOW_X, 16'd1023);
      write_csr(CSR_WINDOW_Y, 16'd1023);
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b1;
      queue_random(90, 65);
      settle();

      // mid settings, junk in unused window bits, frame closing on a dropped point
      write_csr(CSR_THRESHOLD, 16'($urandom_range(1, 2000)));
      write_csr(CSR_WINDOW_X, {6'($urandom), 10'($urandom_range(0, 15))});
      write_csr(CSR_WINDOW_Y, {6'($urandom), 10'($urandom_range(0, 15))});
      req_idle_en = 1'b1;
      queue_random(110, 66);
      settle();

      write_csr(CSR_THRESHOLD, 16'($urandom_range(0, 300)));
      write_csr(CSR_WINDOW_X, 16'($urandom_range(0, 40)));
      write_csr(CSR_WINDOW_Y, 16'($urandom_range(0, 40)));
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      queue_random(80, 0);
      settle();

      if (errors == 0 && awaited_peaks.size() == 0) begin
         $display("frame_peak_extraction regression: pass");
      end else begin
         $display("frame_peak_extraction regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/fpe_pkg.sv
rtl/core/fpe_dpath.sv
rtl/core/fpe_ctrl.sv
rtl/core/frame_peak_extraction.sv
sim/tb_frame_peak_extraction.sv
